[rtl/p7u_pkg.sv]
`timescale 1ns / 1ps

package p7u_pkg;

  // field and state widths
  localparam int LEN_W     = 18;
  localparam int DATA_W    = 8;
  localparam int CHAR_W    = 7;
  localparam int BUF_W     = 2 * CHAR_W;
  localparam int CNT_W     = 4;
  localparam int FBITS_W   = 4;
  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int PTR_W     = $clog2(MAX_RES);

  localparam logic [LEN_W-1:0]   LEN_MAX       = {LEN_W{1'b1}};
  localparam logic [FBITS_W-1:0] FINAL_BITS_RST = FBITS_W'(DATA_W);

  // scheme codes in the upper five header bits
  localparam logic [4:0] SCH_ASCII = 5'd1;
  localparam logic [4:0] SCH_WIDE  = 5'd2;
  localparam logic [4:0] SCH_SCRUB = 5'd4;

  // result status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TRUNCATED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_MALFORMED   = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ASCII = 2'd1,
    MODE_WIDE  = 2'd2
  } mode_t;

  // decoder state carried between words
  typedef struct packed {
    logic [BUF_W-1:0]   bits;
    logic [CNT_W-1:0]   count;
    mode_t              mode;
    logic [FBITS_W-1:0] final_bits;
    logic [LEN_W-1:0]   produced;
  } dec_state_t;

  // results caused by one input word
  typedef struct packed {
    logic [MAX_RES-1:0][DATA_W-1:0] bytes;
    logic [MAX_RES-1:0]             vld;
    logic                           done;
    logic [1:0]                     status;
    logic [LEN_W-1:0]               length;
  } job_t;

endpackage

[rtl/p7u_decode.sv]
`timescale 1ns / 1ps

module p7u_decode (
  input  p7u_pkg::dec_state_t           st,
  input  logic [p7u_pkg::DATA_W-1:0]    data,
  input  logic                          first,
  input  logic                          last,
  input  logic [p7u_pkg::LEN_W-1:0]     cap,
  output p7u_pkg::dec_state_t           st_next,
  output p7u_pkg::job_t                 job,
  output logic [p7u_pkg::RES_CNT_W-1:0] job_cnt
);
  import p7u_pkg::*;

  logic [4:0]         id;
  logic [FBITS_W-1:0] nb;
  logic [DATA_W-1:0]  masked;
  logic [BUF_W-1:0]   acc;
  logic [CNT_W-1:0]   cnt;
  logic [1:0]         nchar;
  logic               wide;
  logic [2:0]         nemit;
  logic [MAX_RES-1:0] vis;
  logic [RES_CNT_W-1:0] nvis;
  logic [LEN_W:0]     sum;
  logic [LEN_W-1:0]   sat;
  logic [LEN_W:0]     sum_all;
  logic [LEN_W-1:0]   produced_new;
  logic [MAX_RES-1:0][DATA_W-1:0] emit_bytes;

  // bit accumulation and character extraction
  always_comb begin
    id     = data[7:3];
    nb     = (last && st.final_bits >= FBITS_W'(1) && st.final_bits <= FBITS_W'(DATA_W))
             ? st.final_bits : FBITS_W'(DATA_W);
    masked = data & DATA_W'((9'd1 << nb) - 9'd1);
    acc    = st.bits | (BUF_W'(masked) << st.count);
    cnt    = st.count + nb;
    if (cnt >= CNT_W'(BUF_W)) begin
      nchar = 2'd2;
    end else if (cnt >= CNT_W'(CHAR_W)) begin
      nchar = 2'd1;
    end else begin
      nchar = 2'd0;
    end
    wide  = (st.mode == MODE_WIDE);
    nemit = wide ? {nchar, 1'b0} : {1'b0, nchar};
    if (wide) begin
      emit_bytes = {8'h00, {1'b0, acc[BUF_W-1:CHAR_W]}, 8'h00, {1'b0, acc[CHAR_W-1:0]}};
    end else begin
      emit_bytes = {8'h00, 8'h00, {1'b0, acc[BUF_W-1:CHAR_W]}, {1'b0, acc[CHAR_W-1:0]}};
    end
  end

  // capacity check per emitted byte; visible bytes always form a prefix
  always_comb begin
    for (int k = 0; k < MAX_RES; k++) begin
      sum    = {1'b0, st.produced} + (LEN_W+1)'(k);
      sat    = (sum > {1'b0, LEN_MAX}) ? LEN_MAX : sum[LEN_W-1:0];
      vis[k] = (3'(k) < nemit) && (sat < cap);
    end
    nvis         = RES_CNT_W'($countones(vis));
    sum_all      = {1'b0, st.produced} + (LEN_W+1)'(nemit);
    produced_new = (sum_all > {1'b0, LEN_MAX}) ? LEN_MAX : sum_all[LEN_W-1:0];
  end

  // next state and result list
  always_comb begin
    st_next = st;
    job     = '0;
    job_cnt = '0;
    if (first) begin
      st_next.bits       = '0;
      st_next.count      = '0;
      st_next.produced   = '0;
      st_next.final_bits = FBITS_W'(data[2:0]) + FBITS_W'(1);
      st_next.mode       = MODE_IDLE;
      if (id == SCH_ASCII || id == SCH_WIDE) begin
        if (last) begin
          job.done   = 1'b1;
          job.status = ST_MALFORMED;
          job_cnt    = RES_CNT_W'(1);
        end else begin
          st_next.mode = (id == SCH_WIDE) ? MODE_WIDE : MODE_ASCII;
        end
      end else begin
        job.done   = 1'b1;
        job.status = (id == SCH_SCRUB) ? ST_OK : ST_UNSUPPORTED;
        job_cnt    = RES_CNT_W'(1);
      end
    end else if (st.mode == MODE_ASCII || st.mode == MODE_WIDE) begin
      job.bytes        = emit_bytes;
      job.vld          = vis;
      job_cnt          = nvis;
      st_next.produced = produced_new;
      if (last) begin
        job.done      = 1'b1;
        job.status    = (produced_new > cap) ? ST_TRUNCATED : ST_OK;
        job.length    = produced_new;
        st_next.mode  = MODE_IDLE;
        st_next.bits  = '0;
        st_next.count = '0;
        // status-only result when nothing visible came out
        if (nvis == '0) begin
          job.bytes = '0;
          job.vld   = '0;
          job_cnt   = RES_CNT_W'(1);
        end
      end else begin
        case (nchar)
          2'd2: begin
            st_next.bits = '0;
          end
          2'd1: begin
            st_next.bits = acc >> CHAR_W;
          end
          default: begin
            st_next.bits = acc;
          end
        endcase
        st_next.count = cnt - CNT_W'(CHAR_W * nchar);
      end
    end
  end

endmodule

[rtl/packed_7bit_text_unpacker.sv]
`timescale 1ns / 1ps

// channel   signals                                        direction
// input     in_valid, in_stall, data_byte, first_byte,     word in
//           last_byte
// output    res_valid, res_stall, out_byte, out_valid,     word out
//           run_last, record_done, status, total_length
// config    cfg_valid, cfg_ready, cfg_data                 out_capacity write
//
// an input word passes an input register, is decoded combinationally and its
// results (zero to four) land in a result register
// results leave one per cycle while res_stall is low;
// four results per word is the worst case, a wide-mode word giving two characters
// the next word is decoded in the cycle its predecessor's last result is taken
// rst is synchronous; no clearing pass, the block takes words right after reset
// res_stall holds the current result; in_stall rises while a word waits in the input register

module packed_7bit_text_unpacker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [p7u_pkg::DATA_W-1:0]   data_byte,
  input  logic                         first_byte,
  input  logic                         last_byte,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [p7u_pkg::DATA_W-1:0]   out_byte,
  output logic                         out_valid,
  output logic                         run_last,
  output logic                         record_done,
  output logic [1:0]                   status,
  output logic [p7u_pkg::LEN_W-1:0]    total_length,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [p7u_pkg::LEN_W-1:0]    cfg_data
);
  import p7u_pkg::*;

  logic [LEN_W-1:0]     out_capacity;
  logic                 in_full;
  logic [DATA_W-1:0]    in_data;
  logic                 in_first;
  logic                 in_last;
  dec_state_t           st;
  dec_state_t           st_next;
  job_t                 job;
  job_t                 job_next;
  logic [RES_CNT_W-1:0] job_cnt;
  logic [RES_CNT_W-1:0] job_cnt_next;
  logic [PTR_W-1:0]     ptr;
  logic                 at_last;
  logic                 res_take;
  logic                 job_free;
  logic                 in_move;
  logic                 in_take;

  // handshakes
  assign cfg_ready = 1'b1;
  assign res_valid = (job_cnt != '0);
  assign at_last   = ({1'b0, ptr} == job_cnt - RES_CNT_W'(1));
  assign res_take  = res_valid && !res_stall;
  assign job_free  = !res_valid || (res_take && at_last);
  assign in_move   = in_full && job_free;
  assign in_stall  = in_full && !job_free;
  assign in_take   = in_valid && !in_stall;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= LEN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      out_capacity <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (in_move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data  <= data_byte;
      in_first <= first_byte;
      in_last  <= last_byte;
    end
  end

  // one word's decode
  p7u_decode u_decode (
    .st      (st),
    .data    (in_data),
    .first   (in_first),
    .last    (in_last),
    .cap     (out_capacity),
    .st_next (st_next),
    .job     (job_next),
    .job_cnt (job_cnt_next)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.bits       <= '0;
      st.count      <= '0;
      st.mode       <= MODE_IDLE;
      st.final_bits <= FINAL_BITS_RST;
      st.produced   <= '0;
    end else if (in_move) begin
      st <= st_next;
    end
  end

  // result register and drain pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      job_cnt <= '0;
      ptr     <= '0;
    end else if (in_move) begin
      job_cnt <= job_cnt_next;
      ptr     <= '0;
    end else if (res_take) begin
      if (at_last) begin
        job_cnt <= '0;
        ptr     <= '0;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      job <= job_next;
    end
  end

  // result fields
  assign out_byte     = job.bytes[ptr];
  assign out_valid    = job.vld[ptr];
  assign run_last     = at_last;
  assign record_done  = at_last && job.done;
  assign status       = record_done ? job.status : ST_OK;
  assign total_length = record_done ? job.length : '0;

`ifndef NO_ASSERTIONS
  // the drain pointer stays inside the loaded result list
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ({1'b0, ptr} < job_cnt))
    else $error("result pointer beyond result count");

  // a result without data only ever carries the record status
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> record_done)
    else $error("status-only result without record_done");

  // truncation is reported only when the length exceeds capacity
  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    (res_valid && record_done && status == ST_TRUNCATED) |-> (total_length > out_capacity))
    else $error("truncated status with length within capacity");

  // a nonzero status never appears before the record's final result
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_OK) |-> (record_done && run_last))
    else $error("status reported on a non-final result");
`endif

endmodule

[verif/unpack_checker.sv]
`timescale 1ns / 1ps

module unpack_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [p7u_pkg::DATA_W-1:0]  data_byte,
  input  logic                        first_byte,
  input  logic                        last_byte,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  logic [p7u_pkg::DATA_W-1:0]  out_byte,
  input  logic                        out_valid,
  input  logic                        run_last,
  input  logic                        record_done,
  input  logic [1:0]                  status,
  input  logic [p7u_pkg::LEN_W-1:0]   total_length,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [p7u_pkg::LEN_W-1:0]   cfg_data,
  output int                          fail_count,
  output int                          pending,
  output int                          compared
);

  import p7u_pkg::*;

  // one decoded result as it leaves the block
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              has_data;
    logic              word_end;
    logic              done;
    logic [1:0]        status;
    logic [LEN_W-1:0]  length;
  } result_t;

  result_t decoded_q[$];
  result_t word_res [MAX_RES];
  int      word_n;

  // predictor copy of the decoder state and the capacity register
  logic [LEN_W-1:0]   capacity;
  logic [LEN_W-1:0]   produced;
  logic [BUF_W-1:0]   acc_bits;
  logic [CNT_W-1:0]   acc_count;
  logic [FBITS_W-1:0] tail_bits;
  mode_t              mode;

  int mismatches = 0;
  int results_seen = 0;
  int outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;
  assign compared   = results_seen;

  task automatic put_result(input logic [DATA_W-1:0] v, input logic has);
    word_res[word_n]          = '0;
    word_res[word_n].value    = v;
    word_res[word_n].has_data = has;
    word_n++;
  endtask

  // bytes past the capacity are counted but not given out
  task automatic emit_char(input logic [DATA_W-1:0] v);
    if (produced < capacity) put_result(v, 1'b1);
    if (produced < LEN_MAX) produced++;
  endtask

  // status rides on the last result, or on a status-only one
  task automatic close_record(input logic [1:0] st, input logic [LEN_W-1:0] len);
    if (word_n == 0) put_result('0, 1'b0);
    word_res[word_n-1].done   = 1'b1;
    word_res[word_n-1].status = st;
    word_res[word_n-1].length = len;
  endtask

  task automatic decode_word(input logic [DATA_W-1:0] d, input logic f, input logic l);
    logic [4:0]  scheme;
    int unsigned nb;
    int unsigned cnt;
    logic [31:0] merged;
    word_n = 0;
    if (f) begin
      // header: start a new record, dropping any record in progress
      scheme    = d[7:3];
      acc_bits  = '0;
      acc_count = '0;
      produced  = '0;
      tail_bits = {1'b0, d[2:0]} + 4'd1;
      mode      = MODE_IDLE;
      if (scheme == SCH_ASCII || scheme == SCH_WIDE) begin
        if (l) close_record(ST_MALFORMED, '0);
        else mode = (scheme == SCH_ASCII) ? MODE_ASCII : MODE_WIDE;
      end else if (scheme == SCH_SCRUB) begin
        close_record(ST_OK, '0);
      end else begin
        close_record(ST_UNSUPPORTED, '0);
      end
    end else if (mode == MODE_ASCII || mode == MODE_WIDE) begin
      // body: append bits lsb first, emit every full character
      nb = l ? tail_bits : DATA_W;
      if (nb == 0 || nb > DATA_W) nb = DATA_W;
      merged = {18'd0, acc_bits} | ((d & ((1 << nb) - 1)) << acc_count);
      merged = merged & 32'h3FFF;
      cnt = acc_count + nb;
      while (cnt >= CHAR_W) begin
        emit_char({1'b0, merged[6:0]});
        if (mode == MODE_WIDE) emit_char('0);
        merged = merged >> CHAR_W;
        cnt = cnt - CHAR_W;
      end
      acc_bits  = merged[BUF_W-1:0];
      acc_count = cnt[CNT_W-1:0];
      if (l) begin
        close_record((produced > capacity) ? ST_TRUNCATED : ST_OK, produced);
        mode      = MODE_IDLE;
        acc_bits  = '0;
        acc_count = '0;
      end
    end
    if (word_n > 0) word_res[word_n-1].word_end = 1'b1;
    for (int i = 0; i < word_n; i++) decoded_q.push_back(word_res[i]);
  endtask

  // watch the three channels at each edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      capacity    = LEN_MAX;
      produced    = '0;
      acc_bits    = '0;
      acc_count   = '0;
      tail_bits   = FINAL_BITS_RST;
      mode        = MODE_IDLE;
      decoded_q.delete();
      outstanding = 0;
    end else begin
      // outgoing result against the oldest prediction
      if (res_valid && !res_stall) begin
        got = {out_byte, out_valid, run_last, record_done, status, total_length};
        results_seen++;
        if (decoded_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: actual byte %h vld %b last %b done %b st %0d len %0d",
                   $time, got.value, got.has_data, got.word_end, got.done, got.status,
                   got.length);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: mismatch: expected byte %h vld %b last %b done %b st %0d len %0d",
                     $time, want.value, want.has_data, want.word_end, want.done,
                     want.status, want.length);
            $display("%0t:           actual byte %h vld %b last %b done %b st %0d len %0d",
                     $time, got.value, got.has_data, got.word_end, got.done, got.status,
                     got.length);
          end
        end
      end
      // capacity write
      if (cfg_valid && cfg_ready) capacity = cfg_data;
      // incoming word
      if (in_valid && !in_stall) decode_word(data_byte, first_byte, last_byte);
      outstanding = decoded_q.size();
    end
  end

endmodule

[verif/tb_packed_7bit_text_unpacker.sv]
`timescale 1ns / 1ps

module tb_packed_7bit_text_unpacker;

  import p7u_pkg::*;

  localparam int QUIET_CYCLES = 16;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int PHASE_WORDS  = 24;
  localparam int LIMIT_NS     = 30_000_000;

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic [DATA_W-1:0] data_byte  = '0;
  logic              first_byte = 1'b0;
  logic              last_byte  = 1'b0;
  logic              res_stall  = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic [LEN_W-1:0]  cfg_data   = '0;

  logic              in_stall;
  logic              res_valid;
  logic [DATA_W-1:0] out_byte;
  logic              out_valid;
  logic              run_last;
  logic              record_done;
  logic [1:0]        status;
  logic [LEN_W-1:0]  total_length;
  logic              cfg_ready;

  int fail_count;
  int pending;
  int compared;

  // idling controls and stimulus bookkeeping
  bit send_idle = 1'b0;
  bit stall_en  = 1'b0;
  int burst_left = 0;
  int stall_run = 0;
  bit stall_on = 1'b0;
  int words_sent = 0;
  int records_sent = 0;
  int counted = 0;

  always #6 clk = ~clk;

  packed_7bit_text_unpacker DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .record_done  (record_done),
    .status       (status),
    .total_length (total_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  unpack_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_byte     (out_byte),
    .out_valid    (out_valid),
    .run_last     (run_last),
    .record_done  (record_done),
    .status       (status),
    .total_length (total_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .compared     (compared)
  );

  // receiver stalls in runs of random length
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_on  = ($urandom_range(0, 99) < 40);
      stall_run = $urandom_range(1, 6);
    end
    stall_run--;
    res_stall <= stall_en && stall_on;
  end

  // present one word and hold it until taken; gaps fall between bursts
  task automatic send_word(input logic [DATA_W-1:0] d, input logic f, input logic l);
    data_byte  <= d;
    first_byte <= f;
    last_byte  <= l;
    in_valid   <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    words_sent++;
    if (f) records_sent++;
    if (send_idle) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 10);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait for the block to drain and go quiet
  task automatic settle();
    int quiet;
    int waited;
    quiet  = 0;
    waited = 0;
    in_valid <= 1'b0;
    while (quiet < QUIET_CYCLES && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
      if (pending == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_capacity(input logic [LEN_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed records, some broken ones and noise
  task automatic random_record();
    int         kind;
    int         k;
    logic [4:0] sch;
    kind = $urandom_range(0, 99);
    sch  = ($urandom_range(0, 1) == 0) ? SCH_ASCII : SCH_WIDE;
    if (kind < 75) begin
      k = $urandom_range(1, 6);
      send_word({sch, 3'($urandom_range(0, 7))}, 1'b1, 1'b0);
      for (int i = 0; i < k; i++)
        send_word(8'($urandom_range(0, 255)), 1'b0, i == k - 1);
      counted += k + 1;
    end else if (kind < 82) begin
      // header-only record
      send_word({sch, 3'($urandom_range(0, 7))}, 1'b1, 1'b1);
      counted++;
    end else if (kind < 88) begin
      // record cut short; the next header drops it
      k = $urandom_range(1, 3);
      send_word({sch, 3'($urandom_range(0, 7))}, 1'b1, 1'b0);
      for (int i = 0; i < k; i++) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      counted += k + 1;
    end else if (kind < 94) begin
      // scrub or unknown scheme, then ignored trailing words
      if ($urandom_range(0, 1) == 0) begin
        sch = SCH_SCRUB;
      end else begin
        sch = 5'($urandom_range(0, 31));
        while (sch == SCH_ASCII || sch == SCH_WIDE || sch == SCH_SCRUB)
          sch = 5'($urandom_range(0, 31));
      end
      k = $urandom_range(0, 2);
      send_word({sch, 3'($urandom_range(0, 7))}, 1'b1, (k == 0) && $urandom_range(0, 1));
      for (int i = 0; i < k; i++) send_word(8'($urandom_range(0, 255)), 1'b0, i == k - 1);
      counted++;
    end else begin
      // stray body word
      send_word(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    logic [LEN_W-1:0] caps [6];
    caps[0] = LEN_MAX;
    caps[1] = '0;
    caps[2] = 18'd1;
    caps[3] = 18'($urandom_range(2, 12));
    caps[4] = 18'($urandom_range(13, 60));
    caps[5] = LEN_MAX;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_capacity(LEN_MAX);

    // directed words with idling on both sides
    send_idle = 1'b1;
    stall_en  = 1'b1;
    // body words while idle are ignored
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    // scrub, then ignored rest of the record
    send_word({SCH_SCRUB, 3'd0}, 1'b1, 1'b0);
    send_word(8'hAA, 1'b0, 1'b1);
    // unknown schemes at both extremes
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hFF, 1'b1, 1'b0);
    // header-only records
    send_word({SCH_ASCII, 3'd7}, 1'b1, 1'b1);
    send_word({SCH_WIDE, 3'd0}, 1'b1, 1'b1);
    // ascii record, seven bits in the last word
    send_word({SCH_ASCII, 3'd6}, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b0);
    send_word(8'hA5, 1'b0, 1'b0);
    send_word(8'h7F, 1'b0, 1'b1);
    // wide record dropped by a new header mid-record
    send_word({SCH_WIDE, 3'd3}, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b0);
    // wide record, one bit in the last word, leftover bits dropped
    send_word({SCH_WIDE, 3'd0}, 1'b1, 1'b0);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    // last word with no visible data gives a status-only result
    send_word({SCH_ASCII, 3'd0}, 1'b1, 1'b0);
    send_word(8'h81, 1'b0, 1'b0);
    send_word(8'hFE, 1'b0, 1'b1);

    // random phases over several capacities and idling mixes
    for (int p = 0; p < 6; p++) begin
      settle();
      write_capacity(caps[p]);
      send_idle = (p == 1) || (p >= 3);
      stall_en  = (p >= 2);
      counted = 0;
      while (counted < PHASE_WORDS) random_record();
    end

    settle();
    $display("run: %0d words in %0d records, %0d results compared", words_sent,
             records_sent, compared);
    $display("capacities from zero to full scale, broken records and several idling mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(LIMIT_NS);
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/p7u_pkg.sv
rtl/p7u_decode.sv
rtl/packed_7bit_text_unpacker.sv
verif/unpack_checker.sv
verif/tb_packed_7bit_text_unpacker.sv
